/* rtl/dbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Depth back-projection package
// Shared widths, register codes and reset values for the depth pixel
// back-projection pipeline.
// ----------------------------------------------------------------------------
package dbp_pkg;

    // result coordinate, signed 1/16 mm
    localparam int POINT_BITS = 32;
    typedef logic signed [POINT_BITS-1:0] t_point;

    localparam t_point PT_MAX = {1'b0, {(POINT_BITS-1){1'b1}}};
    localparam t_point PT_MIN = {1'b1, {(POINT_BITS-1){1'b0}}};

    // fixed-point formats
    localparam int SUBPIX_BITS = 4;     // Q.4 pixel positions
    localparam int RECIP_BITS  = 24;    // Q0.24 reciprocal focal length
    localparam int CENTRE_BITS = 16;    // Q12.4 principal point
    localparam int PLO_BITS    = 22;    // low slice of the pixel-depth product
    localparam int COEF_BITS   = 18;    // Q2.16 rotation coefficient
    localparam int ROT_FRAC    = 16;
    localparam int TRANS_BITS  = 21;
    localparam int ROW_BITS    = 3 * COEF_BITS;
    localparam int TRANS_REG_BITS = 3 * TRANS_BITS;

    localparam logic [RECIP_BITS-1:0] RECIP_HALF = {1'b1, {(RECIP_BITS-1){1'b0}}};
    localparam logic [ROT_FRAC-1:0]   ROT_HALF   = {1'b1, {(ROT_FRAC-1){1'b0}}};

    // camera-frame stages (S1..S4) and whole pipeline (S1..S7)
    localparam int CAM_STAGES  = 4;
    localparam int PIPE_STAGES = 7;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = TRANS_REG_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_INV_FOCAL_X = 3'd0,
        CFG_INV_FOCAL_Y = 3'd1,
        CFG_PRINCIPAL_X = 3'd2,
        CFG_PRINCIPAL_Y = 3'd3,
        CFG_ROT_ROW0    = 3'd4,
        CFG_ROT_ROW1    = 3'd5,
        CFG_ROT_ROW2    = 3'd6,
        CFG_TRANSLATION = 3'd7
    } t_cfg_idx;

    localparam logic [RECIP_BITS-1:0]     RST_INV_FOCAL  = 24'd27962;
    localparam logic [CENTRE_BITS-1:0]    RST_PRINCIPAL_X = 16'd5120;
    localparam logic [CENTRE_BITS-1:0]    RST_PRINCIPAL_Y = 16'd3840;
    localparam logic [ROW_BITS-1:0]       RST_ROT_ROW0   = 54'h00_0000_0001_0000;
    localparam logic [ROW_BITS-1:0]       RST_ROT_ROW1   = 54'h00_0004_0000_0000;
    localparam logic [ROW_BITS-1:0]       RST_ROT_ROW2   = 54'h10_0000_0000_0000;
    localparam logic [TRANS_REG_BITS-1:0] RST_TRANSLATION = '0;

endpackage
`default_nettype wire

/* rtl/dbp_axis.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Back-projection lane
// One image axis: pixel offset from the principal point, times depth, times
// the reciprocal focal length, rounded half away from zero and saturated.
// Four register stages.
// ----------------------------------------------------------------------------
module dbp_axis #(
    parameter int DEPTH_BITS = 16,
    parameter int PIX_BITS   = 12
) (
    input  logic                             i_clk,
    input  logic [PIX_BITS-1:0]              i_pix,
    input  logic [DEPTH_BITS-1:0]            i_depth,
    input  logic [dbp_pkg::CENTRE_BITS-1:0]  i_centre,
    input  logic [dbp_pkg::RECIP_BITS-1:0]   i_recip,
    output dbp_pkg::t_point                  o_cam
);
    import dbp_pkg::*;

    localparam int W_MAG = (PIX_BITS + SUBPIX_BITS > CENTRE_BITS) ?
                           PIX_BITS + SUBPIX_BITS : CENTRE_BITS;
    localparam int W_DIF = W_MAG + 1;
    localparam int W_P   = W_MAG + DEPTH_BITS;
    localparam int W_HI  = W_P - PLO_BITS;
    localparam int W_SUM = W_P + RECIP_BITS + 1;
    localparam int W_Q   = W_SUM - RECIP_BITS;

    // S1: sign and magnitude of the offset
    logic [W_DIF-1:0]            w_dif;
    logic                        w_neg;
    logic [W_MAG-1:0]            w_mag;
    logic                        r_neg1;
    logic [W_MAG-1:0]            r_mag1;
    logic [DEPTH_BITS-1:0]       r_dep1;

    // S2: offset times depth
    logic                        r_neg2;
    logic [W_P-1:0]              r_p2;

    // S3: partial products with the reciprocal
    logic                        r_neg3;
    logic [PLO_BITS+RECIP_BITS-1:0] r_lo3;
    logic [W_HI+RECIP_BITS-1:0]  r_hi3;

    // S4: round, apply sign, saturate
    logic [W_SUM-1:0]            w_sum;
    logic [W_Q-1:0]              w_q;
    logic [63:0]                 w_q64;
    t_point                      w_cam;
    t_point                      r_cam4;

    always_comb begin
        w_dif = W_DIF'({i_pix, {SUBPIX_BITS{1'b0}}}) - W_DIF'(i_centre);
        w_neg = w_dif[W_DIF-1];
        w_mag = w_neg ? W_MAG'(-w_dif) : w_dif[W_MAG-1:0];
    end

    always_comb begin
        w_sum = (W_SUM'(r_hi3) << PLO_BITS) + W_SUM'(r_lo3) + W_SUM'(RECIP_HALF);
        w_q   = w_sum[W_SUM-1:RECIP_BITS];
        w_q64 = 64'(w_q);
        if (!r_neg3 && w_q64 > 64'h0000_0000_7FFF_FFFF) begin
            w_cam = PT_MAX;
        end else if (r_neg3 && w_q64 > 64'h0000_0000_8000_0000) begin
            w_cam = PT_MIN;
        end else if (r_neg3) begin
            w_cam = -t_point'(w_q64[POINT_BITS-1:0]);
        end else begin
            w_cam = t_point'(w_q64[POINT_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg1 <= w_neg;
        r_mag1 <= w_mag;
        r_dep1 <= i_depth;

        r_neg2 <= r_neg1;
        r_p2   <= r_mag1 * r_dep1;

        r_neg3 <= r_neg2;
        r_lo3  <= r_p2[PLO_BITS-1:0] * i_recip;
        r_hi3  <= r_p2[W_P-1:PLO_BITS] * i_recip;

        r_cam4 <= w_cam;
    end

    assign o_cam = r_cam4;

endmodule
`default_nettype wire

/* rtl/dbp_rigid.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Rigid transform
// Rotates the camera-frame point by a Q2.16 matrix, adds the translation,
// rounds half upward and saturates. Three register stages: products, sums,
// result.
// ----------------------------------------------------------------------------
module dbp_rigid (
    input  logic                                       i_clk,
    input  dbp_pkg::t_point                            i_cam_x,
    input  dbp_pkg::t_point                            i_cam_y,
    input  dbp_pkg::t_point                            i_cam_z,
    input  logic [2:0][dbp_pkg::ROW_BITS-1:0]          i_rot,
    input  logic [dbp_pkg::TRANS_REG_BITS-1:0]         i_trans,
    input  logic                                       i_keep,
    output dbp_pkg::t_point                            o_x,
    output dbp_pkg::t_point                            o_y,
    output dbp_pkg::t_point                            o_z
);
    import dbp_pkg::*;

    localparam int PROD_BITS = COEF_BITS + POINT_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam int SH_BITS   = ACC_BITS - ROT_FRAC;

    t_point                        w_cam  [3];
    logic signed [COEF_BITS-1:0]   w_coef [3][3];
    logic signed [TRANS_BITS-1:0]  w_tr   [3];
    logic signed [ACC_BITS-1:0]    w_bias [3];
    logic signed [PROD_BITS-1:0]   r_prod [3][3];
    logic signed [ACC_BITS-1:0]    r_acc  [3];
    logic signed [SH_BITS-1:0]     w_sh   [3];
    t_point                        w_sat  [3];
    t_point                        r_pt   [3];

    always_comb begin
        w_cam[0] = i_cam_x;
        w_cam[1] = i_cam_y;
        w_cam[2] = i_cam_z;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_coef[k][j] = i_rot[k][COEF_BITS*j +: COEF_BITS];
            end
            w_tr[k]   = i_trans[TRANS_BITS*k +: TRANS_BITS];
            // offset scaled to Q.16 with the rounding half folded in
            w_bias[k] = {{(ACC_BITS-TRANS_BITS-ROT_FRAC){w_tr[k][TRANS_BITS-1]}},
                         w_tr[k], ROT_HALF};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sh[k] = r_acc[k][ACC_BITS-1:ROT_FRAC];
            if ((&w_sh[k][SH_BITS-1:POINT_BITS-1]) ||
                !(|w_sh[k][SH_BITS-1:POINT_BITS-1])) begin
                w_sat[k] = w_sh[k][POINT_BITS-1:0];
            end else if (w_sh[k][SH_BITS-1]) begin
                w_sat[k] = PT_MIN;
            end else begin
                w_sat[k] = PT_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[k][j] <= w_coef[k][j] * w_cam[j];
            end
            r_acc[k] <= r_prod[k][0] + r_prod[k][1] + r_prod[k][2] + w_bias[k];
            // drop the value of a zero-depth sample or a bubble
            r_pt[k]  <= i_keep ? w_sat[k] : '0;
        end
    end

    assign o_x = r_pt[0];
    assign o_y = r_pt[1];
    assign o_z = r_pt[2];

endmodule
`default_nettype wire

/* rtl/depth_pixel_backprojection_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Depth pixel back-projection
// Turns a depth sample and its pixel position into a transformed 3-D point
// in signed 1/16 mm through a pinhole model and a configured rigid transform.
// ----------------------------------------------------------------------------
// The block takes one sample on every clock while start is high and busy is
// low; busy is high only during reset and in the cycle after it. Each sample
// yields exactly one result, shown on o_done for a single cycle, in input
// order: four stages form the camera-frame point (offset, depth product,
// reciprocal partial products, rounding) and three apply the rotation and
// translation. The receiver cannot stall, so nothing holds results back.
// Write configuration only when no sample is in flight.
module depth_pixel_backprojection_top #(
    parameter int DEPTH_BITS       = 16,
    parameter int PIXEL_INDEX_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [DEPTH_BITS-1:0]                i_depth_mm,
    input  logic [PIXEL_INDEX_BITS-1:0]          i_pixel_row,
    input  logic [PIXEL_INDEX_BITS-1:0]          i_pixel_col,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dbp_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [dbp_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output logic                                 o_done,
    output logic                                 o_point_valid,
    output dbp_pkg::t_point                      o_point_x,
    output dbp_pkg::t_point                      o_point_y,
    output dbp_pkg::t_point                      o_point_z
);
    import dbp_pkg::*;

    logic                          r_ready;
    logic [RECIP_BITS-1:0]         r_inv_fx;
    logic [RECIP_BITS-1:0]         r_inv_fy;
    logic [CENTRE_BITS-1:0]        r_cx;
    logic [CENTRE_BITS-1:0]        r_cy;
    logic [2:0][ROW_BITS-1:0]      r_rot;
    logic [TRANS_REG_BITS-1:0]     r_trans;

    logic                          w_accept;
    logic [PIPE_STAGES-1:0]        r_vld;
    logic [PIPE_STAGES-1:0]        r_live;
    logic [DEPTH_BITS-1:0]         r_zdep [CAM_STAGES];

    t_point                        w_cam_x;
    t_point                        w_cam_y;
    t_point                        w_cam_z;

    assign busy        = !r_ready;
    assign o_cfg_ready = r_ready;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_inv_fx <= RST_INV_FOCAL;
            r_inv_fy <= RST_INV_FOCAL;
            r_cx     <= RST_PRINCIPAL_X;
            r_cy     <= RST_PRINCIPAL_Y;
            r_rot[0] <= RST_ROT_ROW0;
            r_rot[1] <= RST_ROT_ROW1;
            r_rot[2] <= RST_ROT_ROW2;
            r_trans  <= RST_TRANSLATION;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_INV_FOCAL_X: r_inv_fx <= i_cfg_data[RECIP_BITS-1:0];
                    CFG_INV_FOCAL_Y: r_inv_fy <= i_cfg_data[RECIP_BITS-1:0];
                    CFG_PRINCIPAL_X: r_cx     <= i_cfg_data[CENTRE_BITS-1:0];
                    CFG_PRINCIPAL_Y: r_cy     <= i_cfg_data[CENTRE_BITS-1:0];
                    CFG_ROT_ROW0:    r_rot[0] <= i_cfg_data[ROW_BITS-1:0];
                    CFG_ROT_ROW1:    r_rot[1] <= i_cfg_data[ROW_BITS-1:0];
                    CFG_ROT_ROW2:    r_rot[2] <= i_cfg_data[ROW_BITS-1:0];
                    CFG_TRANSLATION: r_trans  <= i_cfg_data[TRANS_REG_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // valid and nonzero-depth flags advance alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_live <= '0;
        end else begin
            r_vld  <= {r_vld[PIPE_STAGES-2:0], w_accept};
            r_live <= {r_live[PIPE_STAGES-2:0], w_accept && (i_depth_mm != '0)};
        end
    end

    // depth delayed to meet the camera x and y lanes
    always_ff @(posedge i_clk) begin
        r_zdep[0] <= i_depth_mm;
        for (int i = 1; i < CAM_STAGES; i++) begin
            r_zdep[i] <= r_zdep[i-1];
        end
    end

    assign w_cam_z = t_point'({r_zdep[CAM_STAGES-1], {SUBPIX_BITS{1'b0}}});

    dbp_axis #(
        .DEPTH_BITS (DEPTH_BITS),
        .PIX_BITS   (PIXEL_INDEX_BITS)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_pix    (i_pixel_col),
        .i_depth  (i_depth_mm),
        .i_centre (r_cx),
        .i_recip  (r_inv_fx),
        .o_cam    (w_cam_x)
    );

    dbp_axis #(
        .DEPTH_BITS (DEPTH_BITS),
        .PIX_BITS   (PIXEL_INDEX_BITS)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_pix    (i_pixel_row),
        .i_depth  (i_depth_mm),
        .i_centre (r_cy),
        .i_recip  (r_inv_fy),
        .o_cam    (w_cam_y)
    );

    dbp_rigid u_rigid (
        .i_clk   (i_clk),
        .i_cam_x (w_cam_x),
        .i_cam_y (w_cam_y),
        .i_cam_z (w_cam_z),
        .i_rot   (r_rot),
        .i_trans (r_trans),
        .i_keep  (r_live[PIPE_STAGES-2]),
        .o_x     (o_point_x),
        .o_y     (o_point_y),
        .o_z     (o_point_z)
    );

    assign o_done        = r_vld[PIPE_STAGES-1];
    assign o_point_valid = r_live[PIPE_STAGES-1];

    a_done_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, PIPE_STAGES))
        else $error("result strobe without a matching input transfer");

    a_valid_in_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid |-> o_done)
        else $error("point valid outside a result strobe");

    a_valid_needs_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid |-> $past(i_depth_mm != '0, PIPE_STAGES))
        else $error("point valid for a zero-depth sample");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_point_valid) |->
            (o_point_x == '0 && o_point_y == '0 && o_point_z == '0))
        else $error("invalid point carries nonzero coordinates");

endmodule
`default_nettype wire
